// ----- rtl/core/neighbourhood_filter_3x3_top_defines.svh -----
// ----------------------------------------------------------------------------
// neighbourhood filter assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef NEIGHBOURHOOD_FILTER_3X3_TOP_DEFINES_SVH
`define NEIGHBOURHOOD_FILTER_3X3_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define NF3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("nf3 check failed");
`define NF3_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nf3 implication failed");
`define NF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nf3 next-cycle check failed");
`else
`define NF3_ASSERT(lbl, prop)
`define NF3_ASSERT_IMP(lbl, ante, cons)
`define NF3_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/nf3_pkg.sv -----
// ----------------------------------------------------------------------------
// nf3_pkg
// shared types, constants and kernel arithmetic of the 3x3 filter
// ----------------------------------------------------------------------------
package nf3_pkg;

  localparam int MaxWidthDef = 2048;
  localparam int ChW         = 8;
  localparam int NumCh       = 3;
  localparam int PixW        = ChW * NumCh;
  localparam int RowW        = 12;
  localparam int CfgW        = 12;
  localparam int CfgIdxW     = 2;
  localparam int WinN        = 9;
  localparam int SumW        = 12;

  localparam logic [CfgW-1:0] WidthRst  = 12'd2048;
  localparam logic [CfgW-1:0] HeightRst = 12'd1080;

  // floor(s / 9) for s <= 9 * 255 as (s * 3641) >> 15
  localparam logic [SumW-1:0] Div9Mul   = 12'd3641;
  localparam int              Div9Shift = 15;

  localparam logic [ChW-1:0] ChMax = 8'd255;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef logic [PixW-1:0] pixel_t;

  // window entry 3*i+j: row i (0 oldest), column j (2 newest)
  typedef pixel_t [WinN-1:0] win_t;

  typedef struct packed {
    pixel_t          px;
    logic [RowW-1:0] row;
    logic            interior;
    logic            border;
  } meta_t;

  function automatic logic [SumW-1:0] ch_sum(input win_t w, input logic [1:0] k);
    logic [SumW-1:0] s;
    s = '0;
    for (int i = 0; i < WinN; i++) begin
      s = s + SumW'(w[i][ChW*k +: ChW]);
    end
    return s;
  endfunction

  function automatic logic [ChW-1:0] ch_sharpen(input win_t w, input logic [1:0] k);
    logic [10:0] pos;
    logic [9:0]  neg;
    logic [10:0] diff;
    logic [ChW-1:0] res;
    pos  = 11'(w[4][ChW*k +: ChW]) * 11'd5;
    neg  = 10'(w[1][ChW*k +: ChW]) + 10'(w[7][ChW*k +: ChW])
         + 10'(w[3][ChW*k +: ChW]) + 10'(w[5][ChW*k +: ChW]);
    diff = pos - 11'(neg);
    if (11'(neg) > pos) begin
      res = '0;
    end else if (diff > 11'(ChMax)) begin
      res = ChMax;
    end else begin
      res = diff[ChW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ChW-1:0] div9(input logic [SumW-1:0] s);
    logic [2*SumW-1:0] prod;
    prod = (2*SumW)'(s) * (2*SumW)'(Div9Mul);
    return prod[Div9Shift +: ChW];
  endfunction

endpackage

// ----- rtl/core/neighbourhood_filter_3x3_top.sv -----
// ----------------------------------------------------------------------------
// neighbourhood_filter_3x3_top
// 3x3 box blur / five-point sharpen on a raster rgb pixel stream
// ----------------------------------------------------------------------------
// One pixel is taken per clock when the output does not stall. An input that
// completes an interior pixel and is itself a border pixel yields two output
// transactions, and the input then waits for the output register; every other
// input yields at most one. The stages are input register with line store
// read, window shift with line store write, kernel sums, blur divide into the
// result register. Line stores use one read and one write port each, read at
// the incoming column.
// ----------------------------------------------------------------------------
`include "neighbourhood_filter_3x3_top_defines.svh"

module neighbourhood_filter_3x3_top #(
  parameter int MAX_WIDTH = nf3_pkg::MaxWidthDef,
  localparam int ColW     = $clog2(MAX_WIDTH),
  localparam int OutW     = ((3 * nf3_pkg::ChW + nf3_pkg::RowW + ColW + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nf3_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nf3_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // red_in, green_in, blue_in
  input  logic [nf3_pkg::PixW-1:0]     s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // red_out, green_out, blue_out, out_row, out_column, zero pad
  output logic [OutW-1:0]              m_axis_tdata_o,
  output logic                         m_axis_tlast_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (WW > nf3_pkg::CfgW) ? WW : nf3_pkg::CfgW;
  localparam int RW = nf3_pkg::RowW;

  logic                     mode_q;
  logic [nf3_pkg::CfgW-1:0] width_q, height_q;
  logic [ColW-1:0]          col_q, col_d;
  logic [RW-1:0]            row_q, row_d;

  logic [XW-1:0]   w_eff, w_m1, col_x;
  logic [RW-1:0]   h_eff, h_m1;
  logic            interior, border, col_wrap, row_wrap;
  logic            accept, v1_q, ready2;
  nf3_pkg::meta_t  meta1_q, meta3;
  logic [ColW-1:0] col1_q, col3;
  nf3_pkg::win_t   win;
  logic            v3, ready3;
  nf3_pkg::pixel_t res3, px_out;
  logic [RW-1:0]   row_out;
  logic [ColW-1:0] col_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= nf3_pkg::WidthRst;
      height_q <= nf3_pkg::HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nf3_pkg::CFG_MODE:   mode_q   <= cfg_wdata_i[0];
        nf3_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        nf3_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective frame size and position class of the incoming pixel
  always_comb begin
    if (width_q == '0) begin
      w_eff = XW'(1);
    end else if (XW'(width_q) > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = XW'(width_q);
    end
    h_eff    = (height_q == '0) ? RW'(1) : height_q;
    w_m1     = w_eff - 1'b1;
    h_m1     = h_eff - 1'b1;
    col_x    = XW'(col_q);
    interior = (row_q >= RW'(2)) && (col_x >= XW'(2)) && (row_q <= h_m1) && (col_x <= w_m1);
    border   = (row_q == '0) || (row_q >= h_m1) || (col_q == '0) || (col_x >= w_m1);
    col_wrap = ({1'b0, col_x} + 1'b1) >= {1'b0, w_eff};
    row_wrap = ({1'b0, row_q} + 1'b1) >= {1'b0, h_eff};
    if (col_wrap) begin
      col_d = '0;
      row_d = row_wrap ? '0 : row_q + 1'b1;
    end else begin
      col_d = ColW'(col_x + 1'b1);
      row_d = row_q;
    end
  end

  assign s_axis_tready_o = !v1_q || ready2;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s_axis_tready_o) begin
        v1_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta1_q.px       <= s_axis_tdata_i;
      meta1_q.row      <= row_q;
      meta1_q.interior <= interior;
      meta1_q.border   <= border;
      col1_q           <= col_q;
    end
  end

  nf3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (accept),
    .raddr_i (col_q),
    .shift_i (v1_q && ready2),
    .waddr_i (col1_q),
    .px_i    (meta1_q.px),
    .win_o   (win)
  );

  nf3_filter #(.MAX_WIDTH(MAX_WIDTH)) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .valid_i (v1_q),
    .ready_o (ready2),
    .meta_i  (meta1_q),
    .col_i   (col1_q),
    .win_i   (win),
    .valid_o (v3),
    .ready_i (ready3),
    .meta_o  (meta3),
    .col_o   (col3),
    .res_o   (res3)
  );

  nf3_emit #(.MAX_WIDTH(MAX_WIDTH)) u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3),
    .ready_o (ready3),
    .meta_i  (meta3),
    .col_i   (col3),
    .res_i   (res3),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .px_o    (px_out),
    .row_o   (row_out),
    .col_o   (col_out),
    .last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OutW'({col_out, row_out, px_out});

  `NF3_ASSERT_IMP(a_stall_means_busy, !s_axis_tready_o, v1_q)
  `NF3_ASSERT_IMP(a_interior_col, v1_q && meta1_q.interior,
                  (col1_q >= ColW'(2)) && (meta1_q.row >= RW'(2)))

endmodule

// ----- rtl/core/nf3_ram.sv -----
// ----------------------------------------------------------------------------
// nf3_ram
// generic simple dual-port ram, one write and one registered read-first read
// ----------------------------------------------------------------------------
module nf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/nf3_window.sv -----
// ----------------------------------------------------------------------------
// nf3_window
// two line stores and the sliding 3x3 window of pixels
// ----------------------------------------------------------------------------
module nf3_window #(
  parameter int MAX_WIDTH = nf3_pkg::MaxWidthDef,
  localparam int ColW     = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [ColW-1:0]  raddr_i,
  input  logic             shift_i,
  input  logic [ColW-1:0]  waddr_i,
  input  nf3_pkg::pixel_t  px_i,
  output nf3_pkg::win_t    win_o
);

  nf3_pkg::pixel_t ram_up, ram_lo;
  nf3_pkg::pixel_t rd_up, rd_lo;
  nf3_pkg::pixel_t fwd_up_q, fwd_lo_q;
  logic            fwd_v_q;
  logic            collide;
  nf3_pkg::win_t   win_q, win_d;

  nf3_ram #(.WIDTH(nf3_pkg::PixW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (shift_i),
    .waddr_i (waddr_i),
    .wdata_i (rd_lo),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_up)
  );

  nf3_ram #(.WIDTH(nf3_pkg::PixW), .DEPTH(MAX_WIDTH)) u_lower (
    .clk_i   (clk_i),
    .we_i    (shift_i),
    .waddr_i (waddr_i),
    .wdata_i (px_i),
    .re_i    (re_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_lo)
  );

  // read of the column being written in the same cycle
  assign collide = re_i && shift_i && (raddr_i == waddr_i);
  assign rd_up   = fwd_v_q ? fwd_up_q : ram_up;
  assign rd_lo   = fwd_v_q ? fwd_lo_q : ram_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (re_i) begin
      fwd_v_q <= collide;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      fwd_up_q <= rd_lo;
      fwd_lo_q <= px_i;
    end
  end

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[3*i]   = win_q[3*i+1];
      win_d[3*i+1] = win_q[3*i+2];
    end
    win_d[2] = rd_up;
    win_d[5] = rd_lo;
    win_d[8] = px_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  assign win_o = win_q;

endmodule

// ----- rtl/core/nf3_filter.sv -----
// ----------------------------------------------------------------------------
// nf3_filter
// kernel sums and sharpen stage, then blur divide by nine
// ----------------------------------------------------------------------------
module nf3_filter #(
  parameter int MAX_WIDTH = nf3_pkg::MaxWidthDef,
  localparam int ColW     = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             valid_i,
  output logic             ready_o,
  input  nf3_pkg::meta_t   meta_i,
  input  logic [ColW-1:0]  col_i,
  input  nf3_pkg::win_t    win_i,
  output logic             valid_o,
  input  logic             ready_i,
  output nf3_pkg::meta_t   meta_o,
  output logic [ColW-1:0]  col_o,
  output nf3_pkg::pixel_t  res_o
);

  logic                             v2_q, v3_q;
  logic                             ready3;
  nf3_pkg::meta_t                   meta2_q, meta3_q;
  logic [ColW-1:0]                  col2_q, col3_q;
  logic [nf3_pkg::SumW-1:0]         sum_d [nf3_pkg::NumCh];
  logic [nf3_pkg::SumW-1:0]         sum_q [nf3_pkg::NumCh];
  logic [nf3_pkg::ChW-1:0]          shp_d [nf3_pkg::NumCh];
  logic [nf3_pkg::ChW-1:0]          shp_q [nf3_pkg::NumCh];

  assign ready3  = !v3_q || ready_i;
  assign ready_o = !v2_q || ready3;

  always_comb begin
    for (int k = 0; k < nf3_pkg::NumCh; k++) begin
      sum_d[k] = nf3_pkg::ch_sum(win_i, 2'(k));
      shp_d[k] = nf3_pkg::ch_sharpen(win_i, 2'(k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready_o) begin
        v2_q <= valid_i;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      meta2_q <= meta_i;
      col2_q  <= col_i;
    end
    if (ready3 && v2_q) begin
      meta3_q <= meta2_q;
      col3_q  <= col2_q;
      sum_q   <= sum_d;
      shp_q   <= shp_d;
    end
  end

  always_comb begin
    for (int k = 0; k < nf3_pkg::NumCh; k++) begin
      res_o[nf3_pkg::ChW*k +: nf3_pkg::ChW] = mode_i ? shp_q[k] : nf3_pkg::div9(sum_q[k]);
    end
  end

  assign valid_o = v3_q;
  assign meta_o  = meta3_q;
  assign col_o   = col3_q;

endmodule

// ----- rtl/core/nf3_emit.sv -----
// ----------------------------------------------------------------------------
// nf3_emit
// result register, sends interior result then border pass-through
// ----------------------------------------------------------------------------
`include "neighbourhood_filter_3x3_top_defines.svh"

module nf3_emit #(
  parameter int MAX_WIDTH = nf3_pkg::MaxWidthDef,
  localparam int ColW     = $clog2(MAX_WIDTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  nf3_pkg::meta_t            meta_i,
  input  logic [ColW-1:0]           col_i,
  input  nf3_pkg::pixel_t           res_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output nf3_pkg::pixel_t           px_o,
  output logic [nf3_pkg::RowW-1:0]  row_o,
  output logic [ColW-1:0]           col_o,
  output logic                      last_o
);

  logic            v4_q, int_done_q;
  nf3_pkg::meta_t  meta4_q;
  logic [ColW-1:0] col4_q;
  nf3_pkg::pixel_t res4_q;
  logic            pend, fire, load;

  assign pend    = meta4_q.interior && !int_done_q;
  assign last_o  = !pend || !meta4_q.border;
  assign fire    = v4_q && ready_i;
  assign ready_o = !v4_q || (ready_i && last_o);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q       <= 1'b0;
      int_done_q <= 1'b0;
    end else if (load) begin
      v4_q       <= meta_i.interior || meta_i.border;
      int_done_q <= 1'b0;
    end else if (fire) begin
      if (last_o) begin
        v4_q <= 1'b0;
      end else begin
        int_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      meta4_q <= meta_i;
      col4_q  <= col_i;
      res4_q  <= res_i;
    end
  end

  assign valid_o = v4_q;
  assign px_o    = pend ? res4_q : meta4_q.px;
  assign row_o   = pend ? meta4_q.row - 1'b1 : meta4_q.row;
  assign col_o   = pend ? col4_q - 1'b1 : col4_q;

  `NF3_ASSERT_IMP(a_split_pair, valid_o && !last_o, meta4_q.interior && meta4_q.border)
  `NF3_ASSERT_NEXT(a_pair_follows, fire && !last_o, valid_o && last_o)

endmodule

// ----- tb/sv/neighbourhood_filter_3x3_top_tb.sv -----
// ----------------------------------------------------------------------------
// neighbourhood_filter_3x3_top_tb
// streams raster rgb pixels into the 3x3 blur / sharpen filter under random
// valid and ready gaps, predicts every output pixel with its own line stores
// and window, and compares each result transaction field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module neighbourhood_filter_3x3_top_tb;
  import nf3_pkg::*;

  localparam int MaxW         = MaxWidthDef;
  localparam int ColW         = $clog2(MaxW);
  localparam int ResultW      = ((3 * ChW + RowW + ColW + 7) / 8) * 8;
  localparam int ClkPeriod    = 10;
  localparam int SettleCycles = 8;
  localparam int DrainLimit   = 10000;
  localparam int RandomPixels = 1250;

  // index outside the register map
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  typedef struct packed {
    logic [ChW-1:0]  red;
    logic [ChW-1:0]  green;
    logic [ChW-1:0]  blue;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
  } out_pixel_t;

  class filtered_pixel_board;
    pixel_t      upper_line [MaxW];
    pixel_t      lower_line [MaxW];
    pixel_t      win [3][3];
    int unsigned col_cnt;
    int unsigned row_cnt;
    bit          sharpen;
    int unsigned width_reg;
    int unsigned height_reg;
    out_pixel_t  pending_pixels [$];
    int          errors;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      sharpen    = 1'b0;
      width_reg  = WidthRst;
      height_reg = HeightRst;
      errors     = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (cfg_idx_e'(idx))
        CFG_MODE:   sharpen = val[0];
        CFG_WIDTH:  width_reg = val;
        CFG_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function int unsigned fit_width(int unsigned w);
      if (w < 1) return 1;
      if (w > MaxW) return MaxW;
      return w;
    endfunction

    function int unsigned fit_height();
      return (height_reg < 1) ? 1 : height_reg;
    endfunction

    function int unsigned eff_width();
      return fit_width(width_reg);
    endfunction

    function bit at_frame_start();
      return row_cnt == 0 && col_cnt == 0;
    endfunction

    // pixels left until the current frame wraps, 0 when counters overran
    function int unsigned frame_remaining();
      int unsigned w, h;
      w = eff_width();
      h = fit_height();
      if (row_cnt < h && col_cnt < w) return (h - row_cnt) * w - col_cnt;
      return 0;
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction

    function logic [ChW-1:0] box_mean(int k);
      int sum;
      sum = 0;
      foreach (win[i, j]) sum += int'(win[i][j][ChW*k +: ChW]);
      return ChW'(sum / 9);
    endfunction

    function logic [ChW-1:0] five_point(int k);
      int v;
      v = 5 * int'(win[1][1][ChW*k +: ChW]) - int'(win[0][1][ChW*k +: ChW])
        - int'(win[2][1][ChW*k +: ChW]) - int'(win[1][0][ChW*k +: ChW])
        - int'(win[1][2][ChW*k +: ChW]);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return ChW'(v);
    endfunction

    function out_pixel_t make_pixel(pixel_t px, int unsigned r, int unsigned c);
      out_pixel_t o;
      o.red   = px[23:16];
      o.green = px[15:8];
      o.blue  = px[7:0];
      o.row   = RowW'(r);
      o.col   = ColW'(c);
      o.last  = 1'b0;
      return o;
    endfunction

    function void absorb_pixel(logic [ChW-1:0] red, logic [ChW-1:0] green,
                               logic [ChW-1:0] blue);
      pixel_t     px, up, lo, filt;
      int         w, h, r, c, n;
      out_pixel_t made [2];
      px = {red, green, blue};
      w  = eff_width();
      h  = fit_height();
      r  = row_cnt;
      c  = col_cnt;
      n  = 0;
      up = '0;
      lo = '0;
      if (c < MaxW) begin
        up = upper_line[c];
        lo = lower_line[c];
        upper_line[c] = lo;
        lower_line[c] = px;
      end
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = px;
      if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
        for (int k = 0; k < NumCh; k++) begin
          filt[ChW*k +: ChW] = sharpen ? five_point(k) : box_mean(k);
        end
        made[n] = make_pixel(filt, r - 1, c - 1);
        n++;
      end
      if (r == 0 || r >= h - 1 || c == 0 || c >= w - 1) begin
        made[n] = make_pixel(px, r, c);
        n++;
      end
      if (n > 0) made[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_pixels.push_back(made[i]);
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void match_pixel(logic [ResultW-1:0] data, logic last);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        $error("unexpected transaction: row %0d column %0d", data[35:24], data[46:36]);
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red_out", want.red, data[7:0]);
      compare_field("green_out", want.green, data[15:8]);
      compare_field("blue_out", want.blue, data[23:16]);
      compare_field("out_row", want.row, data[35:24]);
      compare_field("out_column", want.col, data[46:36]);
      compare_field("pad", 0, data[ResultW-1:47]);
      compare_field("last_of_run", want.last, last);
    endfunction

    function void close_out();
      if (pending_pixels.size() != 0) begin
        errors++;
        $error("%0d expected transactions never arrived", pending_pixels.size());
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [PixW-1:0]      s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [ResultW-1:0]   m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  filtered_pixel_board board;
  bit                  quiet_flow;
  int                  pixels_sent;

  neighbourhood_filter_3x3_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("neighbourhood_filter_3x3_top verification failed");
    $finish;
  end

  // result side: random stalls, check every accepted transaction
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = quiet_flow ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid_o !== 1'b1);
      board.match_pixel(m_axis_tdata_o, m_axis_tlast_o);
      @(negedge clk_i);
    end
  end

  function automatic logic [ChW-1:0] pick_channel();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ChMax;
      default: return ChW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return CfgW'($urandom_range(3, 10));
    if (sel < 14) return CfgW'($urandom_range(1, 2));
    if (sel == 14) return '0;
    if (sel == 15) return 12'd4095;
    if (sel == 16) return 12'd2048;
    if (sel == 17) return 12'd2047;
    return CfgW'($urandom_range(11, 64));
  endfunction

  function automatic logic [CfgW-1:0] pick_height();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return CfgW'($urandom_range(3, 8));
    if (sel < 16) return CfgW'($urandom_range(1, 2));
    if (sel == 16) return '0;
    if (sel == 17) return 12'd4095;
    return CfgW'($urandom_range(9, 40));
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // valid stays high into the next transaction unless a gap follows or hold is low
  task automatic send_pixel(input bit hold);
    logic [ChW-1:0] red, green, blue;
    int             gap;
    red   = pick_channel();
    green = pick_channel();
    blue  = pick_channel();
    s_axis_tdata_i  = {blue, green, red};
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
    board.absorb_pixel(red, green, blue);
    pixels_sent++;
    @(negedge clk_i);
    gap = quiet_flow ? 0 : $urandom_range(0, 6);
    if (gap > 0 || !hold) s_axis_tvalid_i = 1'b0;
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic run_pixels(input int count);
    for (int i = 0; i < count; i++) send_pixel(i != count - 1);
  endtask

  // width may only grow at a frame start, so stored lines always cover it
  task automatic reconfigure();
    logic [CfgW-1:0] w;
    if ($urandom_range(0, 1)) write_reg(CFG_MODE, CfgW'($urandom_range(0, 4095)));
    if ($urandom_range(0, 1)) begin
      w = pick_width();
      if (board.at_frame_start() || board.fit_width(w) <= board.eff_width()) begin
        write_reg(CFG_WIDTH, w);
      end
    end
    if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, pick_height());
    if ($urandom_range(0, 7) == 0) write_reg(CfgIdxSpare, CfgW'($urandom_range(0, 4095)));
  endtask

  initial begin
    int unsigned rem;
    int          count;
    int          waited;
    board           = new();
    quiet_flow      = 1'b0;
    pixels_sent     = 0;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_MODE;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset sizes: first row passes through
    run_pixels(3);
    wait_idle();
    // shrink mid-row, blur frame, mode with upper bits set, spare index
    write_reg(CFG_WIDTH, 12'd3);
    write_reg(CFG_HEIGHT, 12'd3);
    write_reg(CFG_MODE, 12'h002);
    write_reg(CfgIdxSpare, 12'hfff);
    run_pixels(7);
    wait_idle();
    write_reg(CFG_MODE, 12'hfff);
    run_pixels(9);
    wait_idle();
    // zero sizes act as one
    write_reg(CFG_WIDTH, '0);
    write_reg(CFG_HEIGHT, '0);
    run_pixels(3);
    wait_idle();
    // oversized width clamps to the line store depth
    write_reg(CFG_WIDTH, 12'd4095);
    run_pixels(3);

    while (pixels_sent < RandomPixels + 25) begin
      quiet_flow = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        wait_idle();
        reconfigure();
      end
      rem = board.frame_remaining();
      if (rem > 0 && rem <= 300 && $urandom_range(0, 3) != 0) begin
        count = rem;
      end else begin
        count = $urandom_range(1, 40);
      end
      run_pixels(count);
    end

    quiet_flow = 1'b0;
    waited     = 0;
    while (board.pending() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("neighbourhood_filter_3x3_top verification clean");
    end else begin
      $display("neighbourhood_filter_3x3_top verification failed");
    end
    $finish;
  end

endmodule
